>>> rtl/core/sensor_reply_packet_parser_core_defines.svh
// Assertion macros shared by the sensor reply packet parser RTL.
// Included by any module that carries concurrent checks; no other dependencies.
`ifndef SENSOR_REPLY_PACKET_PARSER_CORE_DEFINES_SVH
`define SENSOR_REPLY_PACKET_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted (reset active low).
`define SRPP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("srpp assertion failed");
// Clocked check that also holds during reset.
`define SRPP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
    else $error("srpp assertion failed");
`else
`define SRPP_ASSERT(label, clk, rst_n, prop)
`define SRPP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> rtl/core/srpp_pkg.sv
// Shared types and constants for the sensor reply packet parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package srpp_pkg;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TIMEOUT = 1'b0;   // paddr[2] == 0: timeout_ms, read/write
    localparam logic REG_DEVADDR = 1'b1;   // paddr[2] == 1: device address, read only

    localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
    localparam logic [31:0] DEVADDR_RESET  = 32'hFFFF_FFFF;

    // Packet framing
    localparam logic [7:0]  SYNC_FIRST   = 8'hEF;
    localparam logic [7:0]  SYNC_SECOND  = 8'h01;
    localparam int          MAX_PAYLOAD  = 64;
    localparam logic [15:0] LEN_OVERHEAD = 16'd2;
    localparam logic [15:0] LEN_MAX      = 16'(MAX_PAYLOAD) + LEN_OVERHEAD;

    typedef enum logic [1:0] {
        CMD_ARM     = 2'd0,
        CMD_BYTE    = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_OVERRUN = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_HUNT    = 4'd1,
        PH_ADDR0   = 4'd2,
        PH_ADDR1   = 4'd3,
        PH_ADDR2   = 4'd4,
        PH_ADDR3   = 4'd5,
        PH_ID      = 4'd6,
        PH_LEN_HI  = 4'd7,
        PH_LEN_LO  = 4'd8,
        PH_PAYLOAD = 4'd9,
        PH_CK_HI   = 4'd10,
        PH_CK_LO   = 4'd11
    } phase_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
        logic [1:0]  status;
        logic [31:0] source_address;
        logic [7:0]  packet_kind;
        logic [6:0]  payload_length;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/srpp_apb.sv
// APB register file: timeout_ms (read/write) and stored device address (read only).
// Depends on srpp_pkg.
`default_nettype none

module srpp_apb
    import srpp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic [31:0]           device_address,
    output logic      [15:0]           timeout_ms
);

    logic [15:0] timeout_reg;
    logic [15:0] timeout_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Low address bits are ignored; paddr[2] picks the register.
    always_comb
    begin
        timeout_next = timeout_reg;
        if (wr_en && (paddr[2] == REG_TIMEOUT))
        begin
            timeout_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TIMEOUT: prdata = {16'h0000, timeout_reg};
            REG_DEVADDR: prdata = device_address;
            default:     prdata = '0;
        endcase
    end

    assign timeout_ms = timeout_reg;

endmodule

`default_nettype wire

>>> rtl/core/srpp_parser.sv
// Packet parser state and one-item step logic: sync hunt, header, payload, checksum.
// Depends on srpp_pkg; the step result is combinational and registered by the top level.
`default_nettype none

module srpp_parser
    import srpp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire cmd_t        cmd,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] timeout_ms,
    output logic             res_valid,
    output result_t          res,
    output logic [31:0]      device_address
);

    phase_t      phase_reg,    phase_next;
    logic [7:0]  prev_reg,     prev_next;
    logic [31:0] addr_reg,     addr_next;
    logic [7:0]  id_reg,       id_next;
    logic [15:0] length_reg,   length_next;
    logic [6:0]  seen_reg,     seen_next;
    logic [15:0] sum_reg,      sum_next;
    logic [7:0]  ck_hi_reg,    ck_hi_next;
    logic [15:0] ticks_reg,    ticks_next;
    logic [31:0] devaddr_reg,  devaddr_next;

    logic [15:0] len_minus;
    logic [15:0] new_len;
    logic [15:0] sum_plus;
    logic [6:0]  seen_inc;

    assign len_minus = length_reg - LEN_OVERHEAD;
    assign new_len   = {length_reg[15:8], data_byte};
    assign sum_plus  = sum_reg + {8'h00, data_byte};
    assign seen_inc  = seen_reg + 7'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        prev_next    = prev_reg;
        addr_next    = addr_reg;
        id_next      = id_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        sum_next     = sum_reg;
        ck_hi_next   = ck_hi_reg;
        ticks_next   = ticks_reg;
        devaddr_next = devaddr_reg;

        res_valid          = 1'b0;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = 8'h00;
        res.payload_index  = 6'd0;
        res.status         = ST_OK;
        res.source_address = addr_reg;
        res.packet_kind    = id_reg;
        // Length is reported only once it has been accepted.
        res.payload_length = (phase_reg >= PH_PAYLOAD) ? len_minus[6:0] : 7'd0;

        if (fire)
        begin
            if (cmd == CMD_ARM)
            begin
                phase_next  = PH_HUNT;
                prev_next   = 8'h00;
                addr_next   = 32'h0;
                id_next     = 8'h00;
                length_next = 16'h0;
                seen_next   = 7'd0;
                sum_next    = 16'h0;
                ck_hi_next  = 8'h00;
                ticks_next  = 16'h0;
            end
            else if (phase_reg != PH_IDLE)
            begin
                case (cmd)
                    CMD_BYTE:
                    begin
                        case (phase_reg)
                            PH_HUNT:
                            begin
                                if ((prev_reg == SYNC_FIRST) && (data_byte == SYNC_SECOND))
                                begin
                                    phase_next = PH_ADDR0;
                                end
                                else
                                begin
                                    prev_next = data_byte;
                                end
                            end
                            PH_ADDR0:
                            begin
                                addr_next  = {addr_reg[23:0], data_byte};
                                phase_next = PH_ADDR1;
                            end
                            PH_ADDR1:
                            begin
                                addr_next  = {addr_reg[23:0], data_byte};
                                phase_next = PH_ADDR2;
                            end
                            PH_ADDR2:
                            begin
                                addr_next  = {addr_reg[23:0], data_byte};
                                phase_next = PH_ADDR3;
                            end
                            PH_ADDR3:
                            begin
                                addr_next  = {addr_reg[23:0], data_byte};
                                phase_next = PH_ID;
                            end
                            PH_ID:
                            begin
                                id_next    = data_byte;
                                sum_next   = sum_plus;
                                phase_next = PH_LEN_HI;
                            end
                            PH_LEN_HI:
                            begin
                                length_next = {data_byte, 8'h00};
                                sum_next    = sum_plus;
                                phase_next  = PH_LEN_LO;
                            end
                            PH_LEN_LO:
                            begin
                                length_next = new_len;
                                sum_next    = sum_plus;
                                if ((new_len < LEN_OVERHEAD) || (new_len > LEN_MAX))
                                begin
                                    res_valid  = 1'b1;
                                    res.kind   = KIND_STATUS;
                                    res.status = ST_INVALID;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    seen_next  = 7'd0;
                                    phase_next = (new_len == LEN_OVERHEAD) ? PH_CK_HI
                                                                           : PH_PAYLOAD;
                                end
                            end
                            PH_PAYLOAD:
                            begin
                                sum_next          = sum_plus;
                                res_valid         = 1'b1;
                                res.payload_byte  = data_byte;
                                res.payload_index = seen_reg[5:0];
                                seen_next         = seen_inc;
                                if ({9'h000, seen_inc} >= len_minus)
                                begin
                                    phase_next = PH_CK_HI;
                                end
                            end
                            PH_CK_HI:
                            begin
                                ck_hi_next = data_byte;
                                phase_next = PH_CK_LO;
                            end
                            PH_CK_LO:
                            begin
                                res_valid  = 1'b1;
                                res.kind   = KIND_STATUS;
                                phase_next = PH_IDLE;
                                if ({ck_hi_reg, data_byte} == sum_reg)
                                begin
                                    res.status   = ST_OK;
                                    devaddr_next = addr_reg;
                                end
                                else
                                begin
                                    res.status = ST_INVALID;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                    CMD_TICK:
                    begin
                        if (ticks_reg >= timeout_ms)
                        begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_STATUS;
                            res.status = ST_TIMEOUT;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            ticks_next = ticks_reg + 16'd1;
                        end
                    end
                    CMD_OVERRUN:
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ST_INVALID;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            prev_reg    <= 8'h00;
            addr_reg    <= 32'h0;
            id_reg      <= 8'h00;
            length_reg  <= 16'h0;
            seen_reg    <= 7'd0;
            sum_reg     <= 16'h0;
            ck_hi_reg   <= 8'h00;
            ticks_reg   <= 16'h0;
            devaddr_reg <= DEVADDR_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            prev_reg    <= prev_next;
            addr_reg    <= addr_next;
            id_reg      <= id_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            sum_reg     <= sum_next;
            ck_hi_reg   <= ck_hi_next;
            ticks_reg   <= ticks_next;
            devaddr_reg <= devaddr_next;
        end
    end

    assign device_address = devaddr_reg;

endmodule

`default_nettype wire

>>> rtl/core/sensor_reply_packet_parser_core.sv
// Sensor reply packet parser: top level with input register, parser and result register.
// Depends on srpp_pkg, srpp_apb, srpp_parser and the assertion macro header.
//
// Each input item is one event of a reply read: arm, received byte, 1 ms tick or
// receive overrun. An arm starts a read: the parser hunts for the sync pair
// 0xEF 0x01, then takes a 4-byte big-endian address, an id byte and a 16-bit
// length; length minus two payload bytes follow, each delivered as a result
// item (kind 0) as it arrives, then a 16-bit checksum that must match the sum
// of id, length bytes and payload. Every read ends in one status item (kind 1):
// ok, invalid (bad length, checksum or overrun) or timeout (more ticks than
// timeout_ms since arm). Arm during a read drops that read silently; events
// while idle are ignored. Throughput is one item per clock while the output
// is not stalled: an accepted item sits in the input register, the parser
// state and its result are computed in the cycle it is processed and the
// result lands in the output register. in_stall rises only while the output
// register holds a result that is being stalled and a further item waits in
// the input register. Configuration sits on the APB port: offset 0x0 is
// timeout_ms (read/write, reset 500), offset 0x4 returns the device address
// stored by the last good packet (read only, reset all ones). Write
// timeout_ms only while no read is in flight.
`default_nettype none
`include "sensor_reply_packet_parser_core_defines.svh"

module sensor_reply_packet_parser_core
    import srpp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // event input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            command,
    input  wire logic [7:0]            data_byte,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       kind,
    output logic      [7:0]            payload_byte,
    output logic      [5:0]            payload_index,
    output logic      [1:0]            status,
    output logic      [31:0]           source_address,
    output logic      [7:0]            packet_kind,
    output logic      [6:0]            payload_length,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic        in_valid_reg, in_valid_next;
    cmd_t        in_cmd_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;

    logic        advance;     // output side can take a new result this cycle
    logic        fire;        // item in the input register is processed
    logic        in_take;
    logic        res_valid;
    result_t     res;
    logic [15:0] timeout_ms;
    logic [31:0] device_address;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    srpp_apb u_apb (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .device_address (device_address),
        .timeout_ms     (timeout_ms)
    );

    srpp_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .cmd            (in_cmd_reg),
        .data_byte      (in_byte_reg),
        .timeout_ms     (timeout_ms),
        .res_valid      (res_valid),
        .res            (res),
        .device_address (device_address)
    );

    // Input register: refills whenever its item moves on or it is empty.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Result register: valid loads on every processed item, data only with a result; holds while stalled.
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = res_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= cmd_t'(command);
            in_byte_reg <= data_byte;
        end
        if (fire && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_res_reg.kind;
    assign payload_byte   = out_res_reg.payload_byte;
    assign payload_index  = out_res_reg.payload_index;
    assign status         = out_res_reg.status;
    assign source_address = out_res_reg.source_address;
    assign packet_kind    = out_res_reg.packet_kind;
    assign payload_length = out_res_reg.payload_length;

    // A result produced by the parser is presented on the next cycle.
    `SRPP_ASSERT(a_result_registered, clk, rst_n, fire && res_valid |=> out_valid_reg)
    // An item waiting in the input register is never dropped.
    `SRPP_ASSERT(a_item_kept, clk, rst_n, in_valid_reg && !fire |=> in_valid_reg)
    // Taking a new item into a full input register needs the old one to move on.
    `SRPP_ASSERT(a_no_overwrite, clk, rst_n, in_take && in_valid_reg |-> fire)
    // Payload items always carry an ok status field.
    `SRPP_ASSERT(a_payload_status, clk, rst_n, out_valid_reg && out_res_reg.kind == KIND_PAYLOAD |-> out_res_reg.status == ST_OK)

endmodule

`default_nettype wire

>>> tb/sensor_reply_packet_parser_core_tb.sv
// Self-checking testbench for sensor_reply_packet_parser_core: event stimulus, APB setup, checks.
// Depends on srpp_pkg and the core RTL; holds its own shadow parser for result prediction.
module sensor_reply_packet_parser_core_tb;
    import srpp_pkg::*;

    localparam logic [APB_ADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] DEVADDR_ADDR = {REG_DEVADDR, 2'b00};

    // Shadow copy of the parser: tracks the read state, keeps the replies
    // still owed by the block and compares what comes out.
    class reply_shadow;
        phase_t      ph;
        logic [7:0]  prev_byte;
        logic [31:0] addr_acc;
        logic [7:0]  id_byte;
        logic [15:0] len_word;
        logic [6:0]  seen;
        logic [15:0] sum;
        logic [7:0]  ck_hi;
        logic [15:0] ticks;
        logic [31:0] dev_addr;
        logic [15:0] timeout_limit;
        result_t     replies_due[$];
        int          errors;

        function new();
            timeout_limit = TIMEOUT_RESET;
            dev_addr = DEVADDR_RESET;
            ph = PH_IDLE;
            errors = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            prev_byte = 8'd0;
            addr_acc = 32'd0;
            id_byte = 8'd0;
            len_word = 16'd0;
            seen = 7'd0;
            sum = 16'd0;
            ck_hi = 8'd0;
            ticks = 16'd0;
        endfunction

        // Header fields reflect what has arrived so far in this read.
        function result_t build_reply(logic k, logic [1:0] st, logic [7:0] pb, logic [5:0] pi);
            result_t r;
            r.kind = k;
            r.payload_byte = pb;
            r.payload_index = pi;
            r.status = st;
            r.source_address = addr_acc;
            r.packet_kind = id_byte;
            r.payload_length = (ph >= PH_PAYLOAD) ? 7'(len_word - LEN_OVERHEAD) : 7'd0;
            return r;
        endfunction

        function void end_read(logic [1:0] st);
            replies_due.push_back(build_reply(KIND_STATUS, st, 8'd0, 6'd0));
            ph = PH_IDLE;
        endfunction

        function void take_byte(logic [7:0] b);
            case (ph)
                PH_HUNT:
                begin
                    // prev_byte freezes on the sync match
                    if (prev_byte == SYNC_FIRST && b == SYNC_SECOND)
                        ph = PH_ADDR0;
                    else
                        prev_byte = b;
                end
                PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3:
                begin
                    addr_acc = {addr_acc[23:0], b};
                    ph = phase_t'(ph + 4'd1);
                end
                PH_ID:
                begin
                    id_byte = b;
                    sum += b;
                    ph = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_word = {b, 8'd0};
                    sum += b;
                    ph = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_word[7:0] = b;
                    sum += b;
                    if (len_word < LEN_OVERHEAD || len_word > LEN_MAX)
                        end_read(ST_INVALID);
                    else
                    begin
                        seen = 7'd0;
                        if (len_word == LEN_OVERHEAD)
                            ph = PH_CK_HI;
                        else
                            ph = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    sum += b;
                    replies_due.push_back(build_reply(KIND_PAYLOAD, ST_OK, b, seen[5:0]));
                    seen++;
                    if (16'(seen) >= len_word - LEN_OVERHEAD)
                        ph = PH_CK_HI;
                end
                PH_CK_HI:
                begin
                    ck_hi = b;
                    ph = PH_CK_LO;
                end
                PH_CK_LO:
                begin
                    if (ck_hi == sum[15:8] && b == sum[7:0])
                    begin
                        dev_addr = addr_acc;
                        end_read(ST_OK);
                    end
                    else
                        end_read(ST_INVALID);
                end
                default:
                    ;
            endcase
        endfunction

        // Called once per accepted input item.
        function void note_event(logic [1:0] cmd, logic [7:0] b);
            if (cmd == CMD_ARM)
            begin
                clear_packet();
                ph = PH_HUNT;
            end
            else if (ph != PH_IDLE)
            begin
                case (cmd)
                    CMD_BYTE:
                        take_byte(b);
                    CMD_TICK:
                    begin
                        if (ticks >= timeout_limit)
                            end_read(ST_TIMEOUT);
                        else
                            ticks++;
                    end
                    default:
                        end_read(ST_INVALID);
                endcase
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Called once per accepted result item.
        function void check_reply(result_t got);
            result_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: result item with none expected, expected nothing, got %h",
                         $time, got);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            compare_field("payload_index", 32'(want.payload_index), 32'(got.payload_index));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("source_address", want.source_address, got.source_address);
            compare_field("packet_kind", 32'(want.packet_kind), 32'(got.packet_kind));
            compare_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
        endfunction
    endclass

    // Every input driven to a known value from time zero.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            command = CMD_ARM;
    logic [7:0]            data_byte = 8'd0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  kind;
    logic [7:0]            payload_byte;
    logic [5:0]            payload_index;
    logic [1:0]            status;
    logic [31:0]           source_address;
    logic [7:0]            packet_kind;
    logic [6:0]            payload_length;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    reply_shadow shadow = new();
    int          events_sent = 0;
    bit          send_quiet = 1'b0;   // sender stretch with no gaps
    bit          rush = 1'b0;         // forces back-to-back items
    bit          hold_request = 1'b0; // asks the receiver for one long stall

    sensor_reply_packet_parser_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .payload_index  (payload_index),
        .status         (status),
        .source_address (source_address),
        .packet_kind    (packet_kind),
        .payload_length (payload_length),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 clk = ~clk;

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    // One input item: random gap, then hold valid until accepted.
    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_event(logic [1:0] c, logic [7:0] b);
        int gap;
        if ($urandom_range(0, 31) == 0)
            send_quiet = !send_quiet;
        gap = (send_quiet || rush) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        shadow.note_event(c, b);
        events_sent++;
    endtask

    // Full reply frame after an arm: optional junk before the sync pair, header,
    // payload and checksum (optionally corrupted) when the length is legal. Ticks are
    // sprinkled in at tick_pct percent. cut_at >= 0 replaces that frame byte with
    // an overrun or a fresh arm and drops the rest.
    task automatic send_reply(logic [15:0] len, bit corrupt, int cut_at, int noise_max,
                              int tick_pct);
        logic [7:0]  frame[$];
        logic [7:0]  b;
        logic [15:0] csum;
        frame = {};
        repeat ($urandom_range(0, noise_max))
            frame.push_back(8'($urandom));
        frame.push_back(SYNC_FIRST);
        frame.push_back(SYNC_SECOND);
        repeat (4)
            frame.push_back(8'($urandom));
        b = 8'($urandom);
        frame.push_back(b);
        csum = 16'(b) + 16'(len[15:8]) + 16'(len[7:0]);
        frame.push_back(len[15:8]);
        frame.push_back(len[7:0]);
        if (len >= LEN_OVERHEAD && len <= LEN_MAX)
        begin
            repeat (int'(len - LEN_OVERHEAD))
            begin
                b = 8'($urandom);
                csum += b;
                frame.push_back(b);
            end
            if (corrupt)
                csum ^= 16'($urandom_range(1, 16'hFFFF));
            frame.push_back(csum[15:8]);
            frame.push_back(csum[7:0]);
        end
        send_event(CMD_ARM, 8'($urandom));
        foreach (frame[i])
        begin
            if (i == cut_at)
            begin
                send_event($urandom_range(0, 1) ? CMD_OVERRUN : CMD_ARM, 8'($urandom));
                return;
            end
            if ($urandom_range(0, 99) < tick_pct)
                send_event(CMD_TICK, 8'($urandom));
            send_event(CMD_BYTE, frame[i]);
        end
    endtask

    // Mostly short payloads; now and then the maximum, empty, and illegal lengths.
    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return LEN_OVERHEAD + 16'($urandom_range(0, 12));
        if (r < 70)
            return LEN_OVERHEAD + 16'($urandom_range(13, MAX_PAYLOAD));
        if (r < 76)
            return LEN_MAX;
        if (r < 80)
            return LEN_OVERHEAD;
        if (r < 85)
            return 16'($urandom_range(0, 1));
        if (r < 90)
            return LEN_MAX + 16'd1;
        return 16'($urandom);
    endfunction

    // Arm then a run of ticks; with a small limit the count straddles the timeout.
    task automatic send_tick_burst();
        int k;
        send_event(CMD_ARM, 8'($urandom));
        if (shadow.timeout_limit <= 16'd40)
            k = int'(shadow.timeout_limit) + $urandom_range(0, 3);
        else
            k = $urandom_range(0, 20);
        repeat (k)
            send_event(CMD_TICK, 8'($urandom));
    endtask

    // Random mix: mostly well-formed frames, plus tick bursts and raw noise.
    task automatic run_traffic(int count, int tick_pct);
        int start;
        int r;
        start = events_sent;
        while (events_sent - start < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                send_reply(pick_length(), $urandom_range(0, 5) == 0,
                           ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : -1,
                           3, tick_pct);
            else if (r < 87)
                send_tick_burst();
            else
                repeat ($urandom_range(1, 6))
                    send_event(2'($urandom), 8'($urandom));
        end
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] a, logic [APB_DATA_W-1:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(logic [APB_ADDR_W-1:0] a, output logic [APB_DATA_W-1:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= a;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        d = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        logic [APB_DATA_W-1:0] v;
        apb_read(TIMEOUT_ADDR, v);
        shadow.compare_field("timeout_ms", {16'd0, shadow.timeout_limit}, v);
        apb_read(DEVADDR_ADDR, v);
        shadow.compare_field("device address", shadow.dev_addr, v);
    endtask

    // Close any open read, wait for every owed result, then let the pipe empty
    // (an item with no result may still sit in the input register).
    task automatic settle();
        if (shadow.ph != PH_IDLE)
            send_event(CMD_OVERRUN, 8'd0);
        in_valid <= 1'b0;
        while (shadow.replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reconfigure(logic [15:0] limit);
        settle();
        apb_write(TIMEOUT_ADDR, {16'd0, limit});
        shadow.timeout_limit = limit;
        check_registers();
    endtask

    // Result side: random stall before each item, quiet stretches, and one long
    // hold-off on request so the block backs up into its input.
    initial
    begin
        int      stall_len;
        bit      quiet;
        result_t got;
        quiet = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                quiet = !quiet;
            stall_len = quiet ? 0 : $urandom_range(0, 8);
            if (hold_request)
            begin
                stall_len = 80;
                hold_request = 1'b0;
            end
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got.kind = kind;
            got.payload_byte = payload_byte;
            got.payload_index = payload_index;
            got.status = status;
            got.source_address = source_address;
            got.packet_kind = packet_kind;
            got.payload_length = payload_length;
            shadow.check_reply(got);
        end
    end

    // Main sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_registers();  // reset values of both registers

        // Directed: events while idle are dropped
        send_event(CMD_BYTE, 8'hFF);
        send_event(CMD_TICK, 8'h00);
        send_event(CMD_OVERRUN, 8'hFF);
        // Good frame with empty payload, extreme byte values; checksum 0x0101
        send_event(CMD_ARM, 8'hFF);
        send_event(CMD_BYTE, SYNC_FIRST);
        send_event(CMD_BYTE, SYNC_SECOND);
        send_event(CMD_BYTE, 8'h00);
        send_event(CMD_BYTE, 8'hFF);
        send_event(CMD_BYTE, 8'h00);
        send_event(CMD_BYTE, 8'hFF);
        send_event(CMD_BYTE, 8'hFF);
        send_event(CMD_BYTE, 8'h00);
        send_event(CMD_BYTE, 8'h02);
        send_event(CMD_BYTE, 8'h01);
        send_event(CMD_BYTE, 8'h01);
        // Length field below two
        send_reply(16'd1, 1'b0, -1, 0, 0);
        // Arm in the middle of a hunt abandons silently, then overrun ends the read
        send_event(CMD_ARM, 8'h00);
        send_event(CMD_BYTE, SYNC_FIRST);
        send_event(CMD_ARM, 8'h00);
        send_event(CMD_OVERRUN, 8'h00);
        settle();
        check_registers();  // device address now taken from the good frame
        run_traffic(303, 5);

        // Zero limit: the first tick after arm already times out
        reconfigure(16'd0);
        send_event(CMD_ARM, 8'h00);
        send_event(CMD_TICK, 8'h00);
        run_traffic(303, 2);

        // Top limit; a max-length frame while the receiver holds off, sent back
        // to back so the block has to stall its input
        reconfigure(16'hFFFF);
        hold_request = 1'b1;
        rush = 1'b1;
        send_reply(LEN_MAX, 1'b0, -1, 0, 0);
        rush = 1'b0;
        run_traffic(303, 5);

        reconfigure(16'd5);
        run_traffic(303, 3);

        reconfigure(16'd1);
        run_traffic(303, 2);

        reconfigure(16'($urandom));
        run_traffic(303, 5);

        settle();
        check_registers();
        if (shadow.errors == 0 && shadow.replies_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sensor_reply_packet_parser_core.f
+incdir+rtl/core
rtl/core/srpp_pkg.sv
rtl/core/srpp_apb.sv
rtl/core/srpp_parser.sv
rtl/core/sensor_reply_packet_parser_core.sv
tb/sensor_reply_packet_parser_core_tb.sv
